>>> hdl/vblc_pkg.sv
package vblc_pkg;

  localparam int ROW_BITS = 8;
  localparam logic [7:0] ROW_ADDR_BASE = 8'd1;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_GET     = 2'd1,
    ACT_REFRESH = 2'd2,
    ACT_BCAST   = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] coord_x;
    logic [3:0] coord_y;
    logic [3:0] coord_z;
    logic       voxel_on;
    logic [7:0] ctrl_register;
    logic [7:0] ctrl_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] chain_word;
    logic        latch_after;
    logic        last;
    logic        voxel_read;
  } out_item_t;

  typedef enum logic [1:0] {
    OUT_GET,
    OUT_REF,
    OUT_BCAST
  } out_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      cnt_init;
    logic      cnt_step;
    logic      rd_en;
    logic      rd_coord;
    logic      wr_en;
    logic      load_out;
    out_kind_t out_kind;
  } vblc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dev_last;
    logic row_last;
    logic out_can_load;
  } vblc_status_t;

endpackage

>>> hdl/vblc_ram.sv
module vblc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/vblc_dp.sv
module vblc_dp import vblc_pkg::*; #(
  parameter int NUM_DEVICES = 8,
  parameter int ROWS        = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  in_item_t     in_item,
  input  vblc_cmd_t    cmd,
  output vblc_status_t status,
  output logic         out_valid,
  input  logic         out_ready,
  output out_item_t    out_item
);

  localparam int DEPTH = NUM_DEVICES * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [DW-1:0] DEV_TOP = DW'(NUM_DEVICES - 1);
  localparam logic [RW-1:0] ROW_TOP = RW'(ROWS - 1);

  in_item_t        item_r;
  logic [DW-1:0]   dev_r, dev_nxt, dev_step, dev_use;
  logic [RW-1:0]   row_r, row_nxt, row_step, row_use;
  logic [DEPTH-1:0] vld_r;
  logic            vld_q_r;
  out_item_t       out_item_r, out_item_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            coord_ok;
  logic [AW-1:0]   coord_addr, cnt_addr, rd_addr;
  logic [7:0]      ram_rdata, cur_byte, set_mask, set_byte;
  logic            wr_go;

  // Refresh walks devices from the top down inside each row.
  always_comb begin
    if (dev_r == '0) begin
      dev_step = DEV_TOP;
      row_step = row_r + RW'(1);
    end else begin
      dev_step = dev_r - DW'(1);
      row_step = row_r;
    end
    dev_use = cmd.cnt_step ? dev_step : dev_r;
    row_use = cmd.cnt_step ? row_step : row_r;
    if (cmd.cnt_init) begin
      dev_nxt = DEV_TOP;
      row_nxt = '0;
    end else begin
      dev_nxt = dev_use;
      row_nxt = row_use;
    end
  end

  assign coord_ok = ({1'b0, item_r.coord_x} < 5'(NUM_DEVICES)) &&
                    (item_r.coord_y < 4'(ROW_BITS)) &&
                    ({1'b0, item_r.coord_z} < 5'(ROWS));

  // Rows are stored mirrored: z selects row ROWS-1-z.
  assign coord_addr = AW'(int'(item_r.coord_x) * ROWS + (ROWS - 1) - int'(item_r.coord_z));
  assign cnt_addr   = AW'(int'(dev_use) * ROWS + int'(row_use));
  assign rd_addr    = cmd.rd_coord ? coord_addr : cnt_addr;

  assign cur_byte = vld_q_r ? ram_rdata : '0;
  assign set_mask = 8'(1) << item_r.coord_y[2:0];
  assign set_byte = item_r.voxel_on ? (cur_byte | set_mask) : (cur_byte & ~set_mask);
  assign wr_go    = cmd.wr_en && coord_ok;

  vblc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_go),
    .waddr(coord_addr),
    .wdata(set_byte),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    out_item_nxt = out_item_r;
    if (cmd.load_out) begin
      case (cmd.out_kind)
        OUT_GET: begin
          out_item_nxt.chain_word  = '0;
          out_item_nxt.latch_after = 1'b0;
          out_item_nxt.last        = 1'b1;
          out_item_nxt.voxel_read  = coord_ok & cur_byte[item_r.coord_y[2:0]];
        end
        OUT_REF: begin
          out_item_nxt.chain_word  = {ROW_ADDR_BASE + 8'(row_r), cur_byte};
          out_item_nxt.latch_after = status.dev_last;
          out_item_nxt.last        = status.dev_last & status.row_last;
          out_item_nxt.voxel_read  = 1'b0;
        end
        OUT_BCAST: begin
          out_item_nxt.chain_word  = {item_r.ctrl_register, item_r.ctrl_value};
          out_item_nxt.latch_after = status.dev_last;
          out_item_nxt.last        = status.dev_last;
          out_item_nxt.voxel_read  = 1'b0;
        end
        default: begin
          out_item_nxt = '0;
        end
      endcase
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      dev_r       <= '0;
      row_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      dev_r       <= dev_nxt;
      row_r       <= row_nxt;
      if (wr_go) begin
        vld_r[coord_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.rd_en) begin
      vld_q_r <= vld_r[rd_addr];
    end
  end

  assign status.dev_last     = (dev_r == '0);
  assign status.row_last     = (row_r == ROW_TOP);
  assign status.out_can_load = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hdl/vblc_ctrl.sv
module vblc_ctrl import vblc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  action_t      in_action,
  output logic         in_ready,
  output vblc_cmd_t    cmd,
  input  vblc_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_GET_RD,
    S_GET_EMIT,
    S_REF_RD,
    S_REF_EMIT,
    S_BCAST
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture  = 1'b1;
          cmd.cnt_init = 1'b1;
          case (in_action)
            ACT_SET:     state_nxt = S_SET_RD;
            ACT_GET:     state_nxt = S_GET_RD;
            ACT_REFRESH: state_nxt = S_REF_RD;
            ACT_BCAST:   state_nxt = S_BCAST;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_SET_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_coord = 1'b1;
        state_nxt    = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      S_GET_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_coord = 1'b1;
        state_nxt    = S_GET_EMIT;
      end
      S_GET_EMIT: begin
        cmd.out_kind = OUT_GET;
        if (status.out_can_load) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_REF_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_REF_EMIT;
      end
      S_REF_EMIT: begin
        cmd.out_kind = OUT_REF;
        if (status.out_can_load) begin
          cmd.load_out = 1'b1;
          if (status.dev_last && status.row_last) begin
            state_nxt = S_IDLE;
          end else begin
            // Fetch the next word while this one goes out.
            cmd.cnt_step = 1'b1;
            cmd.rd_en    = 1'b1;
          end
        end
      end
      S_BCAST: begin
        cmd.out_kind = OUT_BCAST;
        if (status.out_can_load) begin
          cmd.load_out = 1'b1;
          if (status.dev_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

>>> hdl/voxel_buffer_led_chain_refresh.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_item  (in_item_t)
// out_      output     out_valid / out_ready  out_item (out_item_t)
//
// One item is processed at a time. Set reads the stored byte, then writes it back
// modified; get reads the byte, then emits the result after any output stall.
// Refresh emits NUM_DEVICES*ROWS words: one frame buffer read per word through the
// single RAM read port, prefetched while the previous word is delivered.
// Broadcast emits NUM_DEVICES words. The frame buffer reads as dark after
// reset through per-entry valid bits; there is no clearing pass. A stall on
// out_ready holds the output register and pauses the word sequence.
module voxel_buffer_led_chain_refresh import vblc_pkg::*; #(
  parameter int NUM_DEVICES = 8,
  parameter int ROWS        = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  vblc_cmd_t    cmd;
  vblc_status_t status;

  vblc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_item.action),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  vblc_dp #(
    .NUM_DEVICES(NUM_DEVICES),
    .ROWS       (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

>>> hdl/vblc_checker.sv
module vblc_checker import vblc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // in_ready is low in the cycle after an item is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted on consecutive cycles");

  // A get result carries no driver word.
  a_get_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.voxel_read |-> out_item.chain_word == 16'd0 &&
      out_item.last && !out_item.latch_after)
    else $error("get result with driver word");

  // A final word without a load strobe can only be a get result.
  a_last_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last && !out_item.latch_after |->
      out_item.chain_word == 16'd0)
    else $error("final word without load strobe");

endmodule

bind voxel_buffer_led_chain_refresh vblc_checker u_vblc_checker (.*);
